/* design/cptp_pkg.sv */
// ----------------------------------------------------------------------------
// Coordinate pair text parser package
// Token phases, character codes and defaults shared by the parser.
// ----------------------------------------------------------------------------
package cptp_pkg;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_LETTERS = 2'd1,
      PH_DIGITS  = 2'd2,
      PH_BAD     = 2'd3
   } phase_type;

   localparam int COORD_BITS_DEF = 16;

   localparam logic [7:0] SEP_RESET   = 8'd32;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   localparam int COL_RADIX = 26;
   localparam int ROW_RADIX = 10;

   localparam int RSP_DATA_W = 64;

endpackage

/* design/coordinate_pair_text_parser_core.sv */
// ----------------------------------------------------------------------------
// Coordinate pair text parser core
// Parses the first two separator-delimited A1-style squares of a text line
// and emits one result item per line end.
// ----------------------------------------------------------------------------
// A result item is registered and appears in the cycle after the line end.
// Throughput: one character item per cycle when no unread result stalls it;
// a single multiply-add updates the column or row accumulator per item.
// Reset: synchronous, active high; clears the line state and the result
// register and sets the separator to a space.
module coordinate_pair_text_parser_core #(
   parameter int COORD_BITS = cptp_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_we,
   input  logic [7:0]                        csr_wdata,   // separator_char
   // input items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // char_code
   input  logic                              req_tuser,   // has_char
   input  logic                              req_tlast,   // line_end
   // result items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cptp_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // from_col[14:0],
                                                          // from_row[15:0],
                                                          // to_col[14:0],
                                                          // to_row[15:0], pad
   output logic                              rsp_tuser    // move_valid
);
   import cptp_pkg::*;

   localparam int EFF_BITS = (COORD_BITS < 16) ? COORD_BITS : 16;
   localparam int COL_W    = EFF_BITS;
   localparam int ROW_W    = EFF_BITS - 1;
   localparam int CMUL_W   = EFF_BITS + 5;
   localparam int RMUL_W   = EFF_BITS + 3;
   localparam logic [CMUL_W-1:0] COL_LIMIT = CMUL_W'(1) << (EFF_BITS - 1);
   localparam logic [RMUL_W-1:0] ROW_LIMIT = (RMUL_W'(1) << (EFF_BITS - 1)) - RMUL_W'(1);

   logic [7:0]       sep_ff;
   logic [1:0]       done_ff, done_in;
   phase_type        phase_ff, phase_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] fcol_ff, fcol_in;
   logic [ROW_W-1:0] frow_ff, frow_in;
   logic             fail_ff, fail_in;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic              accept;
   logic [7:0]        up_char;
   logic              is_letter, is_digit;
   logic [4:0]        letter_val;
   logic [3:0]        digit_val;
   logic [CMUL_W-1:0] col_prod;
   logic [RMUL_W-1:0] row_prod;
   logic              line_ok;
   logic [14:0]       from_col_w, to_col_w;
   logic [15:0]       from_row_w, to_row_w;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      up_char    = (req_tdata inside {[CHAR_LO_A:CHAR_LO_Z]}) ? req_tdata - CASE_OFFSET
                                                              : req_tdata;
      is_letter  = up_char inside {[CHAR_UP_A:CHAR_UP_Z]};
      is_digit   = req_tdata inside {[CHAR_ZERO:CHAR_NINE]};
      letter_val = 5'(up_char - CHAR_UP_A + 8'd1);
      digit_val  = 4'(req_tdata - CHAR_ZERO);
      col_prod   = CMUL_W'(col_ff) * CMUL_W'(COL_RADIX) + CMUL_W'(letter_val);
      row_prod   = RMUL_W'(row_ff) * RMUL_W'(ROW_RADIX) + RMUL_W'(digit_val);
   end

   // next line state
   always_comb begin
      done_in  = done_ff;
      phase_in = phase_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      fcol_in  = fcol_ff;
      frow_in  = frow_ff;
      fail_in  = fail_ff;
      line_ok  = 1'b0;

      if (req_tuser && !fail_ff && done_ff != 2'd2) begin
         if (req_tdata == sep_ff) begin
            if (phase_ff != PH_IDLE) begin
               if (phase_ff == PH_DIGITS) begin
                  done_in = done_ff + 2'd1;
                  if (done_in == 2'd1) begin
                     fcol_in = col_ff;
                     frow_in = row_ff;
                     col_in  = '0;
                     row_in  = '0;
                  end
               end else begin
                  fail_in = 1'b1;
               end
               phase_in = PH_IDLE;
            end
         end else if (phase_ff != PH_BAD) begin
            if (is_letter) begin
               if ((phase_ff == PH_IDLE || phase_ff == PH_LETTERS) &&
                   col_prod <= COL_LIMIT) begin
                  col_in   = COL_W'(col_prod);
                  phase_in = PH_LETTERS;
               end else begin
                  phase_in = PH_BAD;
               end
            end else if (is_digit) begin
               if ((phase_ff == PH_LETTERS || phase_ff == PH_DIGITS) &&
                   row_prod <= RMUL_W'(ROW_LIMIT)) begin
                  row_in   = ROW_W'(row_prod);
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_BAD;
               end
            end else begin
               phase_in = PH_BAD;
            end
         end
      end

      if (req_tlast) begin
         // close the open token
         if (!fail_in && done_in != 2'd2 && phase_in != PH_IDLE) begin
            if (phase_in == PH_DIGITS) begin
               done_in = done_in + 2'd1;
               if (done_in == 2'd1) begin
                  fcol_in = col_in;
                  frow_in = row_in;
                  col_in  = '0;
                  row_in  = '0;
               end
            end else begin
               fail_in = 1'b1;
            end
            phase_in = PH_IDLE;
         end
         line_ok = !fail_in && done_in == 2'd2;
      end
   end

   // result payload
   always_comb begin
      from_col_w  = 15'(fcol_in) - 15'd1;
      from_row_w  = 16'(frow_in) - 16'd1;
      to_col_w    = 15'(col_in) - 15'd1;
      to_row_w    = 16'(row_in) - 16'd1;
      rsp_user_in = line_ok;
      if (line_ok) begin
         rsp_data_in = {2'b00, to_row_w, to_col_w, from_row_w, from_col_w};
      end else begin
         rsp_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= SEP_RESET;
      end else if (csr_we) begin
         sep_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         phase_ff <= PH_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         fcol_ff  <= '0;
         frow_ff  <= '0;
         fail_ff  <= 1'b0;
      end else if (accept) begin
         if (req_tlast) begin
            done_ff  <= '0;
            phase_ff <= PH_IDLE;
            col_ff   <= '0;
            row_ff   <= '0;
            fcol_ff  <= '0;
            frow_ff  <= '0;
            fail_ff  <= 1'b0;
         end else begin
            done_ff  <= done_in;
            phase_ff <= phase_in;
            col_ff   <= col_in;
            row_ff   <= row_in;
            fcol_ff  <= fcol_in;
            frow_ff  <= frow_in;
            fail_ff  <= fail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_data_ff <= '0;
         rsp_user_ff <= 1'b0;
      end else if (accept && req_tlast) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_done_range: assert property (@(posedge clock) disable iff (reset)
      done_ff != 2'd3)
      else $error("token count out of range");

   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> phase_ff == PH_IDLE && done_ff == 2'd0 && !fail_ff)
      else $error("line state not cleared after line end");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_user_ff |-> rsp_data_ff == '0)
      else $error("invalid result carries nonzero squares");

   a_col_limit: assert property (@(posedge clock) disable iff (reset)
      CMUL_W'(col_ff) <= COL_LIMIT)
      else $error("column accumulator above limit");

endmodule

/* sim/tb_coordinate_pair_text_parser_core.sv */
// ----------------------------------------------------------------------------
// Coordinate pair text parser core testbench
// Drives text lines into the parser one character item at a time. A small
// scoreboard predicts the move result of each line and checks every result
// item, field by field, in order. Directed lines come first, then random
// well-formed, corrupted and garbage lines under several separators and
// idle/stall profiles, including a long receiver hold-off.
// ----------------------------------------------------------------------------

typedef struct {
   bit valid;
   int from_col;
   int from_row;
   int to_col;
   int to_row;
} parsed_move_type;

class move_scoreboard;
   localparam int EFF_BITS = (cptp_pkg::COORD_BITS_DEF < 16) ? cptp_pkg::COORD_BITS_DEF : 16;
   localparam int unsigned COL_LIMIT = 1 << (EFF_BITS - 1);
   localparam int unsigned ROW_LIMIT = (1 << (EFF_BITS - 1)) - 1;

   logic [7:0]           separator;
   int unsigned          squares_done;
   cptp_pkg::phase_type  phase;
   int unsigned          col_acc;
   int unsigned          row_acc;
   int unsigned          first_col;
   int unsigned          first_row;
   bit                   failed;
   parsed_move_type      pending[$];
   int                   errors;

   function new();
      separator = cptp_pkg::SEP_RESET;
      errors = 0;
      clear_line();
   endfunction

   function void clear_line();
      squares_done = 0;
      phase = cptp_pkg::PH_IDLE;
      col_acc = 0;
      row_acc = 0;
      first_col = 0;
      first_row = 0;
      failed = 1'b0;
   endfunction

   function bit parsing();
      return !failed && squares_done < 2;
   endfunction

   function void end_token();
      if (!parsing() || phase == cptp_pkg::PH_IDLE) return;
      if (phase == cptp_pkg::PH_DIGITS) begin
         squares_done++;
         if (squares_done == 1) begin
            first_col = col_acc;
            first_row = row_acc;
            col_acc = 0;
            row_acc = 0;
         end
      end else begin
         failed = 1'b1;
      end
      phase = cptp_pkg::PH_IDLE;
   endfunction

   function void take_char(logic [7:0] c);
      logic [7:0]  up;
      int unsigned v;
      if (!parsing()) return;
      if (c == separator) begin
         end_token();
         return;
      end
      if (phase == cptp_pkg::PH_BAD) return;
      up = (c >= cptp_pkg::CHAR_LO_A && c <= cptp_pkg::CHAR_LO_Z) ?
           c - cptp_pkg::CASE_OFFSET : c;
      if (up >= cptp_pkg::CHAR_UP_A && up <= cptp_pkg::CHAR_UP_Z) begin
         if (phase == cptp_pkg::PH_IDLE || phase == cptp_pkg::PH_LETTERS) begin
            v = col_acc * cptp_pkg::COL_RADIX + (up - cptp_pkg::CHAR_UP_A + 1);
            if (v > COL_LIMIT) begin
               phase = cptp_pkg::PH_BAD;
            end else begin
               col_acc = v;
               phase = cptp_pkg::PH_LETTERS;
            end
         end else begin
            phase = cptp_pkg::PH_BAD;
         end
      end else if (c >= cptp_pkg::CHAR_ZERO && c <= cptp_pkg::CHAR_NINE) begin
         if (phase == cptp_pkg::PH_LETTERS || phase == cptp_pkg::PH_DIGITS) begin
            v = row_acc * cptp_pkg::ROW_RADIX + (c - cptp_pkg::CHAR_ZERO);
            if (v > ROW_LIMIT) begin
               phase = cptp_pkg::PH_BAD;
            end else begin
               row_acc = v;
               phase = cptp_pkg::PH_DIGITS;
            end
         end else begin
            phase = cptp_pkg::PH_BAD;
         end
      end else begin
         phase = cptp_pkg::PH_BAD;
      end
   endfunction

   function void note_item(logic [7:0] c, logic has, logic last);
      parsed_move_type m;
      logic [14:0]  col;
      logic [15:0]  row;
      if (has) take_char(c);
      if (!last) return;
      end_token();
      m = '{default: 0};
      if (!failed && squares_done == 2) begin
         m.valid = 1'b1;
         col = 15'(first_col - 1);
         row = 16'(first_row - 1);
         m.from_col = int'(col);
         m.from_row = int'($signed(row));
         col = 15'(col_acc - 1);
         row = 16'(row_acc - 1);
         m.to_col = int'(col);
         m.to_row = int'($signed(row));
      end
      pending.insert(pending.size(), m);
      clear_line();
   endfunction

   function void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   function void check_move(logic [63:0] data, logic flag);
      parsed_move_type m;
      if (pending.size() == 0) begin
         $error("move_valid: expected no item, got %0d", flag);
         errors++;
         return;
      end
      m = pending.pop_front();
      compare_field("move_valid", int'(m.valid), int'(flag));
      compare_field("from_col", m.from_col, int'(data[14:0]));
      compare_field("from_row", m.from_row, int'($signed(data[30:15])));
      compare_field("to_col", m.to_col, int'(data[45:31]));
      compare_field("to_row", m.to_row, int'($signed(data[61:46])));
   endfunction
endclass

module tb_coordinate_pair_text_parser_core;
   import cptp_pkg::*;

   localparam int TIMEOUT_CYCLES  = 400000;
   localparam int ITEMS_PER_PHASE = 185;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic        rsp_tuser;

   move_scoreboard sb = new();

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int          items_sent = 0;
   logic [7:0]  line_q[$];

   coordinate_pair_text_parser_core dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_move(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready) sb.note_item(req_tdata, req_tuser, req_tlast);
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic send_item(input logic [7:0] c, input logic has, input logic last);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= has;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string s, input bit empty_end);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], 1'b1, !empty_end && i == s.len() - 1);
      if (empty_end) send_item(8'h00, 1'b0, 1'b1);
   endtask

   task automatic send_line();
      bit empty_end;
      empty_end = (line_q.size() == 0) || ($urandom_range(0, 7) == 0);
      for (int i = 0; i < line_q.size(); i++) begin
         if ($urandom_range(0, 24) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(line_q[i], 1'b1, !empty_end && i == line_q.size() - 1);
      end
      if (empty_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_separator(input logic [7:0] sep);
      csr_we    <= 1'b1;
      csr_wdata <= sep;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.separator = sep;
   endtask

   function automatic logic [7:0] pick_char();
      logic [7:0] edges[6];
      edges = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A};
      case ($urandom_range(0, 5))
         0: return 8'(CHAR_UP_A + $urandom_range(0, 25));
         1: return 8'(CHAR_LO_A + $urandom_range(0, 25));
         2: return 8'(CHAR_ZERO + $urandom_range(0, 9));
         3: return sb.separator;
         4: return 8'($urandom_range(0, 255));
         default: return edges[$urandom_range(0, 5)];
      endcase
   endfunction

   function automatic int unsigned pick_col();
      case ($urandom_range(0, 9))
         7: return $urandom_range(1, 800);
         8: return $urandom_range(32760, 32775);
         9: return $urandom_range(1, 60000);
         default: return $urandom_range(1, 30);
      endcase
   endfunction

   function automatic int unsigned pick_row();
      case ($urandom_range(0, 9))
         7: return $urandom_range(0, 9999);
         8: return $urandom_range(32760, 32775);
         9: return $urandom_range(0, 60000);
         default: return $urandom_range(0, 99);
      endcase
   endfunction

   // letters are bijective base-26 of col_value (1-based)
   function automatic void append_square(input int unsigned col_value,
                                         input int unsigned row_value);
      logic [7:0]  letters[$];
      logic [7:0]  digits[$];
      int unsigned n;
      n = col_value;
      while (n > 0) begin
         n = n - 1;
         letters.push_front(8'(CHAR_UP_A + n % COL_RADIX +
                               ($urandom_range(0, 1) ? CASE_OFFSET : 8'd0)));
         n = n / COL_RADIX;
      end
      n = row_value;
      do begin
         digits.push_front(8'(CHAR_ZERO + n % ROW_RADIX));
         n = n / ROW_RADIX;
      end while (n > 0);
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 2)) digits.push_front(CHAR_ZERO);
      line_q = {line_q, letters, digits};
   endfunction

   function automatic void build_line();
      line_q.delete();
      if ($urandom_range(0, 9) >= 8) begin
         repeat ($urandom_range(0, 10)) line_q = {line_q, pick_char()};
         return;
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) line_q = {line_q, sb.separator};
      append_square(pick_col(), pick_row());
      repeat ($urandom_range(1, 3)) line_q = {line_q, sb.separator};
      append_square(pick_col(), pick_row());
      if ($urandom_range(0, 3) == 0) begin
         line_q = {line_q, sb.separator};
         repeat ($urandom_range(1, 4)) line_q = {line_q, pick_char()};
      end
      if ($urandom_range(0, 3) == 0) line_q = {line_q, sb.separator};
      if ($urandom_range(0, 6) == 0)
         line_q[$urandom_range(0, line_q.size() - 1)] = pick_char();
   endfunction

   initial begin
      logic [7:0] sep;
      int         target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("a0  Z9", 1'b0);          // lower case, row 0, empty token
      send_text("B2 C3 x", 1'b1);         // extra token, line end with no char
      send_text("1A", 1'b0);              // digit first
      send_text("", 1'b1);                // empty line
      send_text("AVLH32767 A1", 1'b0);    // largest column and row
      send_text("AVLI1", 1'b0);           // column overflow
      drain();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin sep = SEP_RESET; send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sep = 8'h2C;     send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin sep = 8'h00;     send_idle_pct = 0;  recv_stall_pct = 77; end
            3: begin sep = 8'hFF;     send_idle_pct = 6;  recv_stall_pct = 6;  end
            4: begin sep = 8'h42;     send_idle_pct = 77; recv_stall_pct = 0;  end
            5: begin sep = 8'h35;     send_idle_pct = 0;  recv_stall_pct = 77; end
            6: begin sep = 8'($urandom_range(0, 255)); send_idle_pct = 0; recv_stall_pct = 0; end
            default: begin sep = SEP_RESET; send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         write_separator(sep);
         if (p == 0) hold_request = 1'b1;
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            build_line();
            send_line();
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
